[design/b32d_pkg.sv]
// Shared types, symbol-class codes and the character classifier for the
// base32 text decoder. No dependencies.
package b32d_pkg;

    localparam int QueueDepth = 2;
    localparam int CountW     = $clog2(QueueDepth + 1);
    localparam int PtrW       = $clog2(QueueDepth);

    // symbol classes
    localparam logic [1:0] KIND_SKIP = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] value;
    } sym_t;

    // one classified character as it travels from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] value;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic              full;
        logic              empty;
    } q_status_t;

    // map one ASCII character to its 5-bit code, or skip / bad
    function automatic sym_t classify(input logic [7:0] c);
        sym_t s;
        s.kind  = KIND_BAD;
        s.value = 5'd0;
        unique case (c) inside
            8'h20, 8'h09, 8'h0D, 8'h0A, 8'h2D:
            begin
                s.kind = KIND_SKIP;
            end
            8'h30:
            begin
                s.kind  = KIND_DATA;
                s.value = 5'd14;
            end
            8'h31:
            begin
                s.kind  = KIND_DATA;
                s.value = 5'd11;
            end
            8'h38:
            begin
                s.kind  = KIND_DATA;
                s.value = 5'd1;
            end
            [8'h41:8'h5A], [8'h61:8'h7A]:
            begin
                s.kind  = KIND_DATA;
                s.value = c[4:0] - 5'd1;
            end
            [8'h32:8'h37]:
            begin
                s.kind  = KIND_DATA;
                s.value = c[4:0] + 5'd8;
            end
            default:
            begin
                s.kind  = KIND_BAD;
                s.value = 5'd0;
            end
        endcase
        return s;
    endfunction

endpackage

[design/b32d_if.sv]
// Valid/ready channel interfaces for characters in and results out.
// Depends on nothing.
interface b32d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface b32d_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       bad_char;
    logic       end_mark;

    modport source (output valid, output byte_out, output byte_valid,
                    output bad_char, output end_mark, input ready);
    modport sink   (input valid, input byte_out, input byte_valid,
                    input bad_char, input end_mark, output ready);
endinterface

[design/b32d_front.sv]
// Front end: accept characters, classify them, drop plain skips.
// Depends on b32d_pkg and b32d_if.
module b32d_front
(
    b32d_char_if.sink        chars,
    output logic             push_valid,
    input  logic             push_ready,
    output b32d_pkg::item_t  push_item
);

    b32d_pkg::sym_t sym;

    always_comb
    begin
        sym             = b32d_pkg::classify(chars.char_in);
        push_item.kind  = sym.kind;
        push_item.value = sym.value;
        push_item.last  = chars.last_char;
        // a skipped character that does not end the message has no effect: drop it
        push_valid      = chars.valid &&
                          ((sym.kind != b32d_pkg::KIND_SKIP) || chars.last_char);
        chars.ready     = push_ready;
    end

endmodule

[design/b32d_queue.sv]
// Short FIFO of classified items between front and back.
// Depends on b32d_pkg.
module b32d_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  b32d_pkg::item_t       push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output b32d_pkg::item_t       pop_item,
    output b32d_pkg::q_status_t   status
);

    b32d_pkg::item_t                    entry_reg [b32d_pkg::QueueDepth];
    logic [b32d_pkg::PtrW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [b32d_pkg::PtrW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [b32d_pkg::CountW-1:0]        count_reg, count_next;
    logic                               do_push, do_pop;

    always_comb
    begin
        status.count = count_reg;
        status.full  = (count_reg == b32d_pkg::CountW'(b32d_pkg::QueueDepth));
        status.empty = (count_reg == '0);
        push_ready   = !status.full;
        pop_valid    = !status.empty;
        pop_item     = entry_reg[rd_ptr_reg];
        do_push      = push_valid && push_ready;
        do_pop       = pop_valid && pop_ready;

        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == b32d_pkg::PtrW'(b32d_pkg::QueueDepth - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == b32d_pkg::PtrW'(b32d_pkg::QueueDepth - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/b32d_back.sv]
// Back end: bit store, byte extraction, error tracking and result register.
// Depends on b32d_pkg and b32d_if.
module b32d_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  b32d_pkg::item_t   pop_item,
    b32d_result_if.source     results
);

    logic [11:0] store_reg, store_next;
    logic [3:0]  held_reg, held_next;
    logic        discard_reg, discard_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        byte_valid_reg, byte_valid_next;
    logic        bad_reg, bad_next;
    logic        end_reg, end_next;

    logic        take;
    logic [11:0] shifted_store;
    logic [3:0]  held_sum;
    logic [2:0]  shift;
    logic [11:0] extracted;
    logic        res_byte_valid, res_bad;
    logic [7:0]  res_byte;

    always_comb
    begin
        pop_ready = !out_valid_reg || results.ready;
        take      = pop_valid && pop_ready;

        shifted_store  = {store_reg[6:0], pop_item.value};
        held_sum       = held_reg + 4'd5;
        shift          = 3'(held_sum - 4'd8);
        extracted      = shifted_store >> shift;

        store_next     = store_reg;
        held_next      = held_reg;
        discard_next   = discard_reg;
        res_byte       = 8'd0;
        res_byte_valid = 1'b0;
        res_bad        = 1'b0;

        if (discard_reg)
        begin
            res_bad = pop_item.last;
        end
        else if (pop_item.kind == b32d_pkg::KIND_DATA)
        begin
            store_next = shifted_store;
            if (held_sum >= 4'd8)
            begin
                res_byte       = extracted[7:0];
                res_byte_valid = 1'b1;
                held_next      = held_sum - 4'd8;
            end
            else
            begin
                held_next = held_sum;
            end
        end
        else if (pop_item.kind == b32d_pkg::KIND_BAD)
        begin
            res_bad      = 1'b1;
            discard_next = 1'b1;
        end

        // end of message: return to the reset state
        if (pop_item.last)
        begin
            store_next   = '0;
            held_next    = '0;
            discard_next = 1'b0;
        end

        out_valid_next  = out_valid_reg;
        byte_next       = byte_reg;
        byte_valid_next = byte_valid_reg;
        bad_next        = bad_reg;
        end_next        = end_reg;
        if (take)
        begin
            out_valid_next  = res_byte_valid || res_bad || pop_item.last;
            byte_next       = res_byte;
            byte_valid_next = res_byte_valid;
            bad_next        = res_bad;
            end_next        = pop_item.last;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        results.valid      = out_valid_reg;
        results.byte_out   = byte_reg;
        results.byte_valid = byte_valid_reg;
        results.bad_char   = bad_reg;
        results.end_mark   = end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg     <= '0;
            held_reg      <= '0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                store_reg   <= store_next;
                held_reg    <= held_next;
                discard_reg <= discard_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        byte_valid_reg <= byte_valid_next;
        bad_reg        <= bad_next;
        end_reg        <= end_next;
    end

endmodule

[design/base32_text_decoder_core.sv]
// Top level of the lenient base32 text decoder: front, queue and back.
// Depends on b32d_pkg, b32d_if, b32d_front, b32d_queue and b32d_back.
//
//  Channel   Dir  Beat contents
//  -------   ---  ---------------------------------------------------
//  chars     in   char_in[7:0], last_char
//  results   out  byte_out[7:0], byte_valid, bad_char, end_mark
//
// One character beat is taken every cycle while the two-entry queue has room;
// its result is written to the back-end result register as the back takes it.
// The back end processes one item per cycle while results is not stalled,
// bounded by the combinational shift-and-extract of the bit store.
// rst_n clears the queue, the bit store, the error flag and the result valid flag.
// A stall on results backs up into the queue, then into chars.ready.
module base32_text_decoder_core
(
    input  logic           clk,
    input  logic           rst_n,
    b32d_char_if.sink      chars,
    b32d_result_if.source  results
);

    // front to queue
    logic                 push_valid;
    logic                 push_ready;
    b32d_pkg::item_t      push_item;

    // queue to back
    logic                 pop_valid;
    logic                 pop_ready;
    b32d_pkg::item_t      pop_item;
    b32d_pkg::q_status_t  q_status;

    // classify each character; drop plain whitespace and hyphens here
    b32d_front u_front
    (
        .chars      (chars),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // hold classified items so front and back stall on their own
    b32d_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .status     (q_status)
    );

    // advance the bit store and register one result per item that needs one
    b32d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .results   (results)
    );

`ifndef SYNTH
    // queue fill never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= b32d_pkg::CountW'(b32d_pkg::QueueDepth))
    else $error("queue count beyond depth");

    // the front only forwards a skip when it ends the message
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && (pop_item.kind == b32d_pkg::KIND_SKIP)) |-> pop_item.last)
    else $error("plain skip reached the back end");

    // a last item taken by the back always yields an end-marked result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready && pop_item.last) |=> (results.valid && results.end_mark))
    else $error("end of message gave no end result");

    // an error result never carries a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.bad_char) |-> !results.byte_valid)
    else $error("error result carries a byte");
`endif

endmodule

[tb/tb_base32_text_decoder_core.sv]
// Self-checking testbench for base32_text_decoder_core: random valid/ready
// traffic on both channels, checked beat by beat against an in-bench decoder.
// Depends on b32d_if.sv and the decoder RTL.
module tb_base32_text_decoder_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS      = 650;
    localparam int TAIL_ITEMS        = 60;     // final stretch driven with no idling
    localparam int DRAIN_CYCLES      = 8;      // wait after the drain, with margin
    localparam int CYCLE_LIMIT       = 300000;
    localparam int MAX_REPORTS       = 10;
    localparam logic [4:0] DIGIT_BASE = 5'd26;

    // how the decoder treats one character
    typedef enum logic [1:0] {CLASS_SKIP, CLASS_SYMBOL, CLASS_INVALID} char_class_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       error;
        logic       eom;
    } decoded_t;

    logic clk;
    logic rst_n;

    b32d_char_if   chars_if();
    b32d_result_if results_if();

    base32_text_decoder_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping. Counters other than offered_count are only written at
    // the rising edge, so anything reading them at the falling edge sees settled values.
    // ------------------------------------------------------------------
    char_beat_t pending_chars[$];
    decoded_t   expected_results[$];
    int         pushed_total   = 0;
    int         accepted_count = 0;
    int         offered_count  = 0;
    int         fail_count     = 0;
    int         cycle_count    = 0;
    int         tail_start     = 32'h7FFF_FFFF;

    // in-bench copy of the decoder state
    logic [11:0] store_bits;
    logic [3:0]  store_count;
    logic        aborting;

    // ------------------------------------------------------------------
    // Character classification: skip set, letters of either case, digits
    // 2..7, and the look-alike digits 0, 1 and 8 folded onto O, L and B.
    // ------------------------------------------------------------------
    function automatic char_class_t classify_char(input logic [7:0] c, output logic [4:0] value);
        logic [7:0] folded;
        value  = 5'd0;
        folded = c;
        if (c == "0")
            folded = "O";
        else if (c == "1")
            folded = "L";
        else if (c == "8")
            folded = "B";
        if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == "-")
            return CLASS_SKIP;
        if ((folded >= "A" && folded <= "Z") || (folded >= "a" && folded <= "z"))
        begin
            value = folded[4:0] - 5'd1;
            return CLASS_SYMBOL;
        end
        if (folded >= "2" && folded <= "7")
        begin
            value = folded[4:0] - 5'd18 + DIGIT_BASE;   // '2' has low bits 5'd18
            return CLASS_SYMBOL;
        end
        return CLASS_INVALID;
    endfunction

    // Advance the decoder by one accepted character and queue the result it
    // causes, if any. A last character always causes one, and then wipes
    // the state for the next message.
    task automatic decode_char(input logic [7:0] c, input logic last);
        decoded_t    res;
        logic [4:0]  value;
        char_class_t kind;
        logic        emit;
        res     = '0;
        res.eom = last;
        emit    = last;
        if (aborting)
        begin
            // drop everything until the end of the message
            res.error = last;
        end
        else
        begin
            kind = classify_char(c, value);
            if (kind == CLASS_INVALID)
            begin
                res.error = 1'b1;
                aborting  = 1'b1;
                emit      = 1'b1;
            end
            else if (kind == CLASS_SYMBOL)
            begin
                store_bits  = {store_bits[6:0], value};
                store_count = store_count + 4'd5;
                if (store_count >= 4'd8)
                begin
                    res.data       = 8'(store_bits >> (store_count - 4'd8));
                    res.data_valid = 1'b1;
                    store_count    = store_count - 4'd8;
                    emit           = 1'b1;
                end
            end
        end
        if (emit)
            expected_results.push_back(res);
        if (last)
        begin
            store_bits  = '0;
            store_count = '0;
            aborting    = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_char(input logic [7:0] c, input logic last);
        char_beat_t beat;
        beat.code = c;
        beat.last = last;
        pending_chars.push_back(beat);
        pushed_total++;
    endtask

    function automatic logic [7:0] pick_symbol_char();
        case ($urandom_range(0, 3))
            0: return 8'("A" + $urandom_range(0, 25));
            1: return 8'("a" + $urandom_range(0, 25));
            2: return 8'("2" + $urandom_range(0, 5));
            default:
            begin
                case ($urandom_range(0, 2))
                    0: return "0";
                    1: return "1";
                    default: return "8";
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_skip_char();
        case ($urandom_range(0, 4))
            0: return " ";
            1: return 8'h09;
            2: return 8'h0D;
            3: return 8'h0A;
            default: return "-";
        endcase
    endfunction

    function automatic logic [7:0] pick_invalid_char();
        logic [7:0] c;
        logic [4:0] unused_value;
        do
            c = 8'($urandom_range(0, 255));
        while (classify_char(c, unused_value) != CLASS_INVALID);
        return c;
    endfunction

    // Mostly well-formed messages with random content, now and then a stray
    // skip or bad character; the rest is raw byte noise with random ends.
    task automatic queue_random_traffic(input int item_count);
        int stop_at;
        int msg_len;
        int roll;
        logic [7:0] c;
        stop_at = pushed_total + item_count;
        while (pushed_total < stop_at)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                msg_len = $urandom_range(1, 24);
                for (int i = 0; i < msg_len; i++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 80)
                        c = pick_symbol_char();
                    else if (roll < 93)
                        c = pick_skip_char();
                    else
                        c = pick_invalid_char();
                    queue_char(c, i == msg_len - 1);
                end
            end
            else
            begin
                msg_len = $urandom_range(1, 10);
                for (int i = 0; i < msg_len; i++)
                    queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // Hold here until every queued beat has been taken and every result seen.
    task automatic wait_for_drain();
        while (accepted_count != pushed_total || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Character driver: present beats at the falling edge, hold a beat until
    // it is taken, and insert idle bursts between beats. Runs of 0..30 beats
    // go out back to back so gaps land on every phase of a message.
    // ------------------------------------------------------------------
    int         send_gap  = 0;
    int         send_run  = 0;
    char_beat_t next_beat;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (chars_if.valid && accepted_count != offered_count)
            begin
                // beat still waiting for ready: hold it
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                chars_if.valid <= 1'b0;
            end
            else if (pending_chars.size() == 0)
            begin
                chars_if.valid <= 1'b0;
            end
            else if (send_run == 0 && accepted_count < tail_start)
            begin
                send_gap = $urandom_range(1, 14) - 1;
                send_run = $urandom_range(0, 30);
                chars_if.valid <= 1'b0;
            end
            else
            begin
                if (send_run > 0)
                    send_run--;
                next_beat = pending_chars.pop_front();
                chars_if.valid     <= 1'b1;
                chars_if.char_in   <= next_beat.code;
                chars_if.last_char <= next_beat.last;
                offered_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: ready with random stall bursts, always ready in the tail.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int take_run   = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                results_if.ready <= 1'b0;
            end
            else if (take_run == 0 && accepted_count < tail_start)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                take_run   = $urandom_range(0, 30);
                results_if.ready <= 1'b0;
            end
            else
            begin
                if (take_run > 0)
                    take_run--;
                results_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, feed a taken character beat to the
    // in-bench decoder and check a taken result beat against the oldest
    // expectation.
    // ------------------------------------------------------------------
    decoded_t seen_result;
    decoded_t want_result;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                decode_char(chars_if.char_in, chars_if.last_char);
                accepted_count++;
            end
            if (results_if.valid && results_if.ready)
            begin
                seen_result.data       = results_if.byte_out;
                seen_result.data_valid = results_if.byte_valid;
                seen_result.error      = results_if.bad_char;
                seen_result.eom        = results_if.end_mark;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("ERROR: unexpected result beat byte=%02h valid=%b bad=%b end=%b",
                                 seen_result.data, seen_result.data_valid,
                                 seen_result.error, seen_result.eom);
                    fail_count++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (seen_result.data       !== want_result.data ||
                        seen_result.data_valid !== want_result.data_valid ||
                        seen_result.error      !== want_result.error ||
                        seen_result.eom        !== want_result.eom)
                    begin
                        if (fail_count < MAX_REPORTS)
                        begin
                            $write("ERROR: result mismatch: expected byte=%02h valid=%b bad=%b",
                                   want_result.data, want_result.data_valid,
                                   want_result.error);
                            $display(" end=%b, got byte=%02h valid=%b bad=%b end=%b",
                                     want_result.eom,
                                     seen_result.data, seen_result.data_valid,
                                     seen_result.error, seen_result.eom);
                        end
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed messages, a full drain, random traffic,
    // then drain and finish.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        chars_if.valid       = 1'b0;
        chars_if.char_in     = 8'h00;
        chars_if.last_char   = 1'b0;
        results_if.ready     = 1'b0;
        store_bits           = '0;
        store_count          = '0;
        aborting             = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // skip set, alphabet extremes A and z, digits 2 and 7, look-alike digits,
        // message ended on a skipped character
        queue_char(" ", 1'b0);
        queue_char(8'h09, 1'b0);
        queue_char(8'h0D, 1'b0);
        queue_char(8'h0A, 1'b0);
        queue_char("-", 1'b0);
        queue_char("A", 1'b0);
        queue_char("z", 1'b0);
        queue_char("2", 1'b0);
        queue_char("7", 1'b0);
        queue_char("0", 1'b0);
        queue_char("1", 1'b0);
        queue_char("8", 1'b0);
        queue_char("m", 1'b0);
        queue_char("Y", 1'b0);
        queue_char("-", 1'b1);
        // NUL aborts after one symbol; the rest is dropped up to a bad last
        queue_char("B", 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char("C", 1'b0);
        queue_char(8'hFF, 1'b1);
        // bad character that is itself the last one
        queue_char(8'hFF, 1'b1);
        // byte completed on the last character
        queue_char("M", 1'b0);
        queue_char("Y", 1'b1);
        // pad character aborts, then a valid last is dropped
        queue_char("=", 1'b0);
        queue_char("a", 1'b1);

        // let the sender sit until every result has come back
        wait_for_drain();
        @(posedge clk);

        queue_random_traffic(RANDOM_ITEMS);
        tail_start = pushed_total - TAIL_ITEMS;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_results.size() == 0 && fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
design/b32d_pkg.sv
design/b32d_if.sv
design/b32d_front.sv
design/b32d_queue.sv
design/b32d_back.sv
design/base32_text_decoder_core.sv
tb/tb_base32_text_decoder_core.sv
